FILE: src/ivm_pkg.sv
package ivm_pkg;

    localparam int VOICES_DEF    = 8;
    localparam int ADDR_BITS_DEF = 16;

    localparam logic [16:0] UNITY_STEP  = 17'h10000;
    localparam logic [16:0] MAX_LENGTH  = 17'h10000;
    localparam logic [7:0]  FULL_GAIN   = 8'd255;
    localparam logic [16:0] GAIN_DIV    = 17'd65025;
    localparam logic [16:0] GAIN_RECIP  = 17'd66051;
    localparam int          MOD_STEPS   = 17;

    typedef enum logic [2:0] {
        OP_MIX      = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_STEP     = 3'd3,
        OP_STOP_ALL = 3'd4,
        OP_WRITE    = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] music_left;
        logic signed [15:0] music_right;
        logic [2:0]         voice_index;
        logic [15:0]        sound_base;
        logic [16:0]        sound_length;
        logic               sound_loop;
        logic [7:0]         volume;
        logic               use_master;
        logic [23:0]        step;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_data;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               start_ok;
        logic [2:0]         started_voice;
        logic [7:0]         active_mask;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_B,
        ST_SUM,
        ST_SCALE,
        ST_DIV,
        ST_ACC,
        ST_MOD,
        ST_MOD_WR,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_a;
        logic rd_b;
        logic mul_b;
        logic sum;
        logic scale;
        logic div;
        logic acc;
        logic mod_step;
        logic mod_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       mixable;
        logic       wrap_loop;
    } stat_t;

endpackage

FILE: src/ivm_ram.sv
module ivm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ivm_ctrl.sv
module ivm_ctrl #(
    parameter int VOICES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ivm_pkg::stat_t        stat,
    output ivm_pkg::cmd_t         cmd,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_sel
);
    import ivm_pkg::*;

    localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICES - 1);

    state_t          state_reg, state_next;
    logic [VI_W-1:0] voice_reg;
    logic [4:0]      cnt_reg;
    logic            out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_EXEC;
            ST_EXEC:   state_next = (stat.op == OP_MIX) ? ST_CHECK : ST_OUT;
            ST_CHECK:  state_next = stat.mixable ? ST_RD_A : ST_NEXT;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:    state_next = ST_ACC;
            ST_ACC:    state_next = stat.wrap_loop ? ST_MOD : ST_NEXT;
            ST_MOD:    if (cnt_reg == 5'(MOD_STEPS - 1)) state_next = ST_MOD_WR;
            ST_MOD_WR: state_next = ST_NEXT;
            ST_NEXT:   state_next = (voice_reg == LAST_VOICE) ? ST_OUT : ST_CHECK;
            ST_OUT:    if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.capture  = in_valid;
            ST_EXEC:   cmd.exec     = 1'b1;
            ST_RD_A:   cmd.rd_a     = 1'b1;
            ST_RD_B:   cmd.rd_b     = 1'b1;
            ST_MUL_B:  cmd.mul_b    = 1'b1;
            ST_SUM:    cmd.sum      = 1'b1;
            ST_SCALE:  cmd.scale    = 1'b1;
            ST_DIV:    cmd.div      = 1'b1;
            ST_ACC:    cmd.acc      = 1'b1;
            ST_MOD:    cmd.mod_step = 1'b1;
            ST_MOD_WR: cmd.mod_wr   = 1'b1;
            ST_OUT:    cmd.load_out = !out_valid_reg || out_ready;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            voice_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC)
            begin
                voice_reg <= '0;
            end
            else if (state_reg == ST_NEXT && voice_reg != LAST_VOICE)
            begin
                voice_reg <= voice_reg + 1'b1;
            end
            if (state_reg == ST_MOD)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign voice_sel = voice_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_mod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (cnt_reg < 5'(MOD_STEPS)))
        else $error("modulo step count overrun");

endmodule

FILE: src/ivm_datapath.sv
module ivm_datapath #(
    parameter int VOICES           = 8,
    parameter int SAMPLE_ADDR_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ivm_pkg::in_word_t     in_data,
    output ivm_pkg::out_word_t    out_data,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_data,
    input  ivm_pkg::cmd_t         cmd,
    output ivm_pkg::stat_t        stat,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_sel
);
    import ivm_pkg::*;

    localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AB    = SAMPLE_ADDR_BITS;
    localparam int SUMW  = ((AB > 16) ? AB : 16) + 1;
    localparam int ACC_W = 17 + $clog2(VOICES + 1);
    localparam int MW    = (VOICES > 8) ? VOICES : 8;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    in_word_t  in_reg;
    out_word_t out_reg;
    logic [7:0] master_reg;

    logic [VOICES-1:0] act_reg;
    logic [VOICES-1:0] loop_reg;
    logic [VOICES-1:0] um_reg;
    logic [31:0]       pos_reg  [VOICES];
    logic [23:0]       step_reg [VOICES];
    logic [AB-1:0]     base_reg [VOICES];
    logic [16:0]       len_reg  [VOICES];
    logic [7:0]        vol_reg  [VOICES];

    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;
    logic                    res_ok_reg;
    logic [2:0]              res_voice_reg;
    logic [15:0]             volgain_reg;
    logic signed [33:0]      p1_reg;
    logic signed [32:0]      p2_reg;
    logic signed [15:0]      s_reg;
    logic signed [32:0]      prod_reg;
    logic [30:0]             ax_reg;
    logic                    neg_reg;
    logic [16:0]             q0_reg;
    logic [16:0]             ip_reg;
    logic [15:0]             lo_reg;
    logic [17:0]             rem_reg;

    logic [VI_W-1:0] vi;
    logic            vi_ok;
    logic            free_found;
    logic [VI_W-1:0] free_idx;
    logic [16:0]     start_len;

    logic [15:0]     idx;
    logic [16:0]     nxt;
    logic [15:0]     off_b;
    logic [AB-1:0]   addr_a, addr_b, raddr;
    logic [15:0]     rdata;
    logic [15:0]     frac;
    logic [32:0]     pos_sum;
    logic            wrap;
    logic [7:0]      gain;
    logic [32:0]     prod_abs;
    logic [47:0]     q0_full;
    logic [47:0]     qd;
    logic [30:0]     rem_est;
    logic [16:0]     q_mag;
    logic signed [ACC_W-1:0] q_s;
    logic [17:0]     rem_sh;
    logic [MW-1:0]   act_pad;
    logic signed [15:0] sat_l, sat_r;

    ivm_ram #(.WIDTH(16), .DEPTH(2 ** AB)) u_ram (
        .clk   (clk),
        .we    (cmd.exec && in_reg.op == OP_WRITE),
        .waddr (AB'(in_reg.sample_address)),
        .wdata (in_reg.sample_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign vi    = VI_W'(in_reg.voice_index);
    assign vi_ok = ({29'd0, in_reg.voice_index} < VOICES);
    assign start_len = (in_reg.sound_length > MAX_LENGTH) ? MAX_LENGTH : in_reg.sound_length;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VI_W'(i);
            end
        end
    end

    // sample addresses of the current voice
    always_comb
    begin
        idx   = pos_reg[voice_sel][31:16];
        frac  = pos_reg[voice_sel][15:0];
        nxt   = {1'b0, idx} + 17'd1;
        off_b = nxt[15:0];
        if (nxt >= len_reg[voice_sel])
        begin
            off_b = loop_reg[voice_sel] ? 16'd0 : idx;
        end
        addr_a = AB'(SUMW'(base_reg[voice_sel]) + SUMW'(idx));
        addr_b = AB'(SUMW'(base_reg[voice_sel]) + SUMW'(off_b));
        raddr  = cmd.rd_b ? addr_b : addr_a;
    end

    assign pos_sum = {1'b0, pos_reg[voice_sel]} + 33'(step_reg[voice_sel]);
    assign wrap    = (pos_sum[32:16] >= len_reg[voice_sel]);
    assign gain    = um_reg[voice_sel] ? master_reg : FULL_GAIN;

    assign stat.op        = in_reg.op;
    assign stat.mixable   = act_reg[voice_sel] && (len_reg[voice_sel] != 17'd0);
    assign stat.wrap_loop = wrap && loop_reg[voice_sel];

    // divide by 65025 via reciprocal, estimate is low by at most one
    assign prod_abs = prod_reg[32] ? 33'(-prod_reg) : 33'(prod_reg);
    assign q0_full  = 48'(prod_abs[30:0]) * 48'(GAIN_RECIP);
    assign qd       = 48'(q0_reg) * 48'(GAIN_DIV);
    assign rem_est  = ax_reg - qd[30:0];
    assign q_mag    = (rem_est >= 31'(GAIN_DIV)) ? q0_reg + 17'd1 : q0_reg;
    assign q_s      = neg_reg ? -ACC_W'(q_mag) : ACC_W'(q_mag);

    assign rem_sh = {rem_reg[16:0], ip_reg[16]};

    assign act_pad = MW'(act_reg);
    assign sat_l = (acc_l_reg > SAT_HI) ? 16'sh7fff :
                   (acc_l_reg < SAT_LO) ? 16'sh8000 : acc_l_reg[15:0];
    assign sat_r = (acc_r_reg > SAT_HI) ? 16'sh7fff :
                   (acc_r_reg < SAT_LO) ? 16'sh8000 : acc_r_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= FULL_GAIN;
            act_reg    <= '0;
            loop_reg   <= '0;
            um_reg     <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                pos_reg[i]  <= '0;
                step_reg[i] <= '0;
                base_reg[i] <= '0;
                len_reg[i]  <= '0;
                vol_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                master_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                case (in_reg.op)
                    OP_START:
                    begin
                        if (free_found)
                        begin
                            act_reg[free_idx]  <= 1'b1;
                            pos_reg[free_idx]  <= '0;
                            step_reg[free_idx] <= 24'(UNITY_STEP);
                            base_reg[free_idx] <= AB'(in_reg.sound_base);
                            len_reg[free_idx]  <= start_len;
                            loop_reg[free_idx] <= in_reg.sound_loop;
                            vol_reg[free_idx]  <= in_reg.volume;
                            um_reg[free_idx]   <= in_reg.use_master;
                        end
                    end
                    OP_STOP:
                    begin
                        if (vi_ok)
                        begin
                            act_reg[vi]  <= 1'b0;
                            pos_reg[vi]  <= '0;
                            step_reg[vi] <= '0;
                            base_reg[vi] <= '0;
                            len_reg[vi]  <= '0;
                            loop_reg[vi] <= 1'b0;
                            vol_reg[vi]  <= '0;
                            um_reg[vi]   <= 1'b0;
                        end
                    end
                    OP_STEP:
                    begin
                        if (vi_ok && act_reg[vi])
                        begin
                            step_reg[vi] <= in_reg.step;
                        end
                    end
                    OP_STOP_ALL:
                    begin
                        act_reg  <= '0;
                        loop_reg <= '0;
                        um_reg   <= '0;
                        for (int i = 0; i < VOICES; i++)
                        begin
                            pos_reg[i]  <= '0;
                            step_reg[i] <= '0;
                            base_reg[i] <= '0;
                            len_reg[i]  <= '0;
                            vol_reg[i]  <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.acc && wrap && !loop_reg[voice_sel])
            begin
                act_reg[voice_sel] <= 1'b0;
            end
            if (cmd.acc && !(wrap && loop_reg[voice_sel]))
            begin
                pos_reg[voice_sel] <= pos_sum[31:0];
            end
            if (cmd.mod_wr)
            begin
                pos_reg[voice_sel] <= {rem_reg[15:0], lo_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.exec)
        begin
            acc_l_reg     <= ACC_W'(in_reg.music_left);
            acc_r_reg     <= ACC_W'(in_reg.music_right);
            res_ok_reg    <= (in_reg.op == OP_START) && free_found;
            res_voice_reg <= ((in_reg.op == OP_START) && free_found) ? 3'(free_idx) : 3'd0;
        end
        if (cmd.rd_a)
        begin
            volgain_reg <= 16'(vol_reg[voice_sel] * gain);
        end
        if (cmd.rd_b)
        begin
            p1_reg <= $signed(rdata) * $signed({1'b0, 17'h10000 - {1'b0, frac}});
        end
        if (cmd.mul_b)
        begin
            p2_reg <= $signed(rdata) * $signed({1'b0, frac});
        end
        if (cmd.sum)
        begin
            s_reg <= 16'(35'(p1_reg) + 35'(p2_reg) >>> 16);
        end
        if (cmd.scale)
        begin
            prod_reg <= s_reg * $signed({1'b0, volgain_reg});
        end
        if (cmd.div)
        begin
            ax_reg  <= prod_abs[30:0];
            neg_reg <= prod_reg[32];
            q0_reg  <= {1'b0, q0_full[47:32]};
        end
        if (cmd.acc)
        begin
            acc_l_reg <= acc_l_reg + q_s;
            acc_r_reg <= acc_r_reg + q_s;
            ip_reg    <= pos_sum[32:16];
            lo_reg    <= pos_sum[15:0];
            rem_reg   <= '0;
        end
        // restoring remainder of the integer position by the length
        if (cmd.mod_step)
        begin
            rem_reg <= (rem_sh >= 18'(len_reg[voice_sel])) ?
                       rem_sh - 18'(len_reg[voice_sel]) : rem_sh;
            ip_reg  <= {ip_reg[15:0], 1'b0};
        end
        if (cmd.load_out)
        begin
            out_reg.left_out      <= (in_reg.op == OP_MIX) ? sat_l : 16'sd0;
            out_reg.right_out     <= (in_reg.op == OP_MIX) ? sat_r : 16'sd0;
            out_reg.start_ok      <= (in_reg.op == OP_START) && res_ok_reg;
            out_reg.started_voice <= (in_reg.op == OP_START) ? res_voice_reg : 3'd0;
            out_reg.active_mask   <= act_pad[7:0];
        end
    end

    assign out_data = out_reg;

endmodule

FILE: src/interpolating_voice_mixer_core.sv
// each word passes accept, execute and output; mix words add per voice check and next
// when skipped, check through next when mixed, plus remainder steps and write on a loop wrap
// the per-voice rate is set by the single read port of the sample ram and the
// 17-step remainder unit that wraps looping positions; one word is in work at a time
// reset clears all voices and sets master volume to 255; sample ram is not cleared
module interpolating_voice_mixer_core #(
    parameter int VOICES           = ivm_pkg::VOICES_DEF,
    parameter int SAMPLE_ADDR_BITS = ivm_pkg::ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ivm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ivm_pkg::out_word_t out_data,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_data
);
    import ivm_pkg::*;

    localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    cmd_t            cmd;
    stat_t           stat;
    logic [VI_W-1:0] voice_sel;

    ivm_ctrl #(.VOICES(VOICES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .voice_sel (voice_sel)
    );

    ivm_datapath #(.VOICES(VOICES), .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .voice_sel (voice_sel)
    );

endmodule

FILE: sim/interpolating_voice_mixer_core_test.sv
`timescale 1ns / 1ps

module interpolating_voice_mixer_core_test;

    import ivm_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    class mix_scoreboard;
        logic [7:0]         master;
        bit                 act[8];
        logic [31:0]        pos[8];
        logic [23:0]        stp[8];
        logic [15:0]        base[8];
        logic [16:0]        len[8];
        bit                 lp[8];
        logic [7:0]         vol[8];
        bit                 um[8];
        logic signed [15:0] mem[65536];
        bit                 written[65536];
        out_word_t          expected_q[$];
        int                 errors;
        int                 mixes;
        int                 starts;
        int                 full_starts;

        function new();
            master = 8'd255;
            for (int v = 0; v < 8; v++)
                clear_voice(v);
        endfunction

        function void clear_voice(int v);
            act[v] = 0;
            pos[v] = '0;
            stp[v] = '0;
            base[v] = '0;
            len[v] = '0;
            lp[v] = 0;
            vol[v] = '0;
            um[v] = 0;
        endfunction

        function int next_index(int v);
            int idx;
            int nxt;
            idx = pos[v][31:16];
            nxt = idx + 1;
            if (nxt >= int'(len[v]))
                nxt = lp[v] ? 0 : idx;
            return nxt;
        endfunction

        // first sample address the next mix would read that holds no data yet
        function int unwritten_address();
            logic [15:0] a0;
            logic [15:0] a1;
            for (int v = 0; v < 8; v++)
            begin
                if (act[v] && len[v] != 0)
                begin
                    a0 = base[v] + pos[v][31:16];
                    a1 = base[v] + 16'(next_index(v));
                    if (!written[a0])
                        return int'(a0);
                    if (!written[a1])
                        return int'(a1);
                end
            end
            return -1;
        endfunction

        function logic signed [15:0] clamp16(longint x);
            if (x > 32767)
                return 16'sd32767;
            if (x < -32768)
                return 16'sh8000;
            return 16'(x);
        endfunction

        function void note_input(in_word_t w);
            out_word_t         r;
            longint            left;
            longint            right;
            longint            a;
            longint            b;
            longint            wsum;
            longint            s;
            longint            g;
            longint unsigned   sm;
            logic [15:0]       frac;
            logic [16:0]       l;
            int                vi;
            r = '0;
            vi = w.voice_index;
            case (w.op)
                OP_MIX:
                begin
                    mixes++;
                    left = w.music_left;
                    right = w.music_right;
                    for (int v = 0; v < 8; v++)
                    begin
                        if (!act[v] || len[v] == 0)
                            continue;
                        frac = pos[v][15:0];
                        a = mem[16'(base[v] + pos[v][31:16])];
                        b = mem[16'(base[v] + 16'(next_index(v)))];
                        wsum = a * (65536 - longint'(frac)) + b * longint'(frac);
                        s = wsum >>> 16;
                        g = um[v] ? longint'(master) : 255;
                        s = (s * longint'(vol[v]) * g) / 65025;
                        left += s;
                        right += s;
                        sm = longint'(pos[v]) + longint'(stp[v]);
                        if ((sm >> 16) >= len[v])
                        begin
                            if (lp[v])
                                sm = sm % (longint'(len[v]) << 16);
                            else
                                act[v] = 0;
                        end
                        pos[v] = sm[31:0];
                    end
                    r.left_out = clamp16(left);
                    r.right_out = clamp16(right);
                end
                OP_START:
                begin
                    full_starts++;
                    for (int v = 0; v < 8; v++)
                    begin
                        if (!act[v])
                        begin
                            l = (w.sound_length > 17'h10000) ? 17'h10000 : w.sound_length;
                            act[v] = 1;
                            pos[v] = '0;
                            stp[v] = 24'h10000;
                            base[v] = w.sound_base;
                            len[v] = l;
                            lp[v] = w.sound_loop;
                            vol[v] = w.volume;
                            um[v] = w.use_master;
                            r.start_ok = 1'b1;
                            r.started_voice = 3'(v);
                            starts++;
                            full_starts--;
                            break;
                        end
                    end
                end
                OP_STOP:
                    clear_voice(vi);
                OP_STEP:
                    if (act[vi])
                        stp[vi] = w.step;
                OP_STOP_ALL:
                    for (int v = 0; v < 8; v++)
                        clear_voice(v);
                OP_WRITE:
                begin
                    mem[w.sample_address] = w.sample_data;
                    written[w.sample_address] = 1;
                end
                default:
                    ;
            endcase
            for (int v = 0; v < 8; v++)
                r.active_mask[v] = act[v];
            expected_q.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.left_out !== e.left_out)
            begin
                $error("left_out expected %0d got %0d", e.left_out, got.left_out);
                errors++;
            end
            if (got.right_out !== e.right_out)
            begin
                $error("right_out expected %0d got %0d", e.right_out, got.right_out);
                errors++;
            end
            if (got.start_ok !== e.start_ok)
            begin
                $error("start_ok expected %0d got %0d", e.start_ok, got.start_ok);
                errors++;
            end
            if (got.started_voice !== e.started_voice)
            begin
                $error("started_voice expected %0d got %0d", e.started_voice,
                       got.started_voice);
                errors++;
            end
            if (got.active_mask !== e.active_mask)
            begin
                $error("active_mask expected %h got %h", e.active_mask, got.active_mask);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    logic      cfg_write = 1'b0;
    logic [7:0] cfg_data = '0;

    mix_scoreboard sb = new();
    int in_idle_pct;
    int out_idle_pct;
    int words_sent;

    interpolating_voice_mixer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic in_word_t noise_word(logic [2:0] op);
        in_word_t w;
        w.op = op;
        w.music_left = 16'($urandom);
        w.music_right = 16'($urandom);
        w.voice_index = 3'($urandom);
        w.sound_base = 16'($urandom);
        w.sound_length = 17'($urandom);
        w.sound_loop = 1'($urandom);
        w.volume = 8'($urandom);
        w.use_master = 1'($urandom);
        w.step = 24'($urandom);
        w.sample_address = 16'($urandom);
        w.sample_data = 16'($urandom);
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    // every sample the coming mix reads gets written first
    task automatic send_mix(in_word_t w);
        int addr;
        in_word_t fill;
        addr = sb.unwritten_address();
        while (addr >= 0)
        begin
            fill = noise_word(OP_WRITE);
            fill.sample_address = 16'(addr);
            send_word(fill);
            addr = sb.unwritten_address();
        end
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_master(logic [7:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.master = value;
    endtask

    task automatic start_voice(logic [15:0] b, logic [16:0] l, bit lpf, logic [7:0] v,
                               bit m);
        in_word_t w;
        w = noise_word(OP_START);
        w.sound_base = b;
        w.sound_length = l;
        w.sound_loop = lpf;
        w.volume = v;
        w.use_master = m;
        send_word(w);
    endtask

    task automatic mix_frame(logic signed [15:0] ml, logic signed [15:0] mr);
        in_word_t w;
        w = noise_word(OP_MIX);
        w.music_left = ml;
        w.music_right = mr;
        send_mix(w);
    endtask

    task automatic voice_cmd(logic [2:0] op, logic [2:0] vi, logic [23:0] s);
        in_word_t w;
        w = noise_word(op);
        w.voice_index = vi;
        w.step = s;
        send_word(w);
    endtask

    task automatic random_word();
        in_word_t w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            w = noise_word(OP_MIX);
        else if (r < 62)
        begin
            w = noise_word(OP_START);
            // sounds share a small region so that sample fills stay few
            if ($urandom_range(0, 9) == 0)
                w.sound_base = 16'($urandom_range(65472, 65535));
            else
                w.sound_base = 16'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0: w.sound_length = '0;
                1: w.sound_length = 17'($urandom_range(65536, 131071));
                2: w.sound_length = 17'($urandom_range(1, 65536));
                default: w.sound_length = 17'($urandom_range(1, 48));
            endcase
        end
        else if (r < 69)
            w = noise_word(OP_STOP);
        else if (r < 81)
        begin
            w = noise_word(OP_STEP);
            if ($urandom_range(0, 7) != 0)
                w.step = 24'($urandom_range(0, 24'h28000));
        end
        else if (r < 83)
            w = noise_word(OP_STOP_ALL);
        else if (r < 96)
            w = noise_word(OP_WRITE);
        else
            w = noise_word($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
        if (w.op == OP_MIX)
            send_mix(w);
        else
            send_word(w);
    endtask

    initial
    begin
        logic [7:0] levels[6];
        in_word_t w;
        levels = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd200, 8'd37};
        levels[5] = 8'($urandom);
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, saturation, allocation corners
        w = noise_word(OP_WRITE); w.sample_address = 16'h0000; w.sample_data = 16'sh7fff;
        send_word(w);
        w = noise_word(OP_WRITE); w.sample_address = 16'h0001; w.sample_data = -16'sh8000;
        send_word(w);
        w = noise_word(OP_WRITE); w.sample_address = 16'hffff; w.sample_data = 16'sh1234;
        send_word(w);
        start_voice(16'h0000, 17'd2, 1'b1, 8'd255, 1'b0);
        mix_frame(16'sh7fff, -16'sh8000);
        voice_cmd(OP_STEP, 3'd0, 24'h008000);
        mix_frame(-16'sh8000, 16'sh7fff);
        voice_cmd(OP_STEP, 3'd5, 24'hffffff);
        start_voice(16'hffff, 17'd0, 1'b0, 8'd0, 1'b1);
        start_voice(16'hffff, 17'h1ffff, 1'b0, 8'd255, 1'b1);
        start_voice(16'h0001, 17'd1, 1'b0, 8'd128, 1'b0);
        mix_frame(16'sh0000, 16'sh0000);
        start_voice(16'h0000, 17'd3, 1'b1, 8'd255, 1'b1);
        start_voice(16'h0000, 17'd1, 1'b1, 8'd255, 1'b0);
        start_voice(16'h0000, 17'd1, 1'b0, 8'd255, 1'b0);
        start_voice(16'h0000, 17'd1, 1'b0, 8'd255, 1'b0);
        start_voice(16'h0000, 17'd1, 1'b0, 8'd255, 1'b0);
        start_voice(16'h0000, 17'd1, 1'b0, 8'd255, 1'b0);
        start_voice(16'h0000, 17'd1, 1'b0, 8'd255, 1'b0);
        voice_cmd(OP_STEP, 3'd1, 24'hffffff);
        mix_frame(16'sh7fff, 16'sh7fff);
        voice_cmd(OP_STOP, 3'd7, 24'h0);
        voice_cmd(OP_SPARE_A, 3'd0, 24'h0);
        voice_cmd(OP_SPARE_B, 3'd0, 24'h0);
        voice_cmd(OP_STOP_ALL, 3'd0, 24'h0);
        mix_frame(-16'sh8000, -16'sh8000);

        for (int phase = 0; phase < 6; phase++)
        begin
            set_master(levels[phase]);
            case (phase % 3)
                0: begin in_idle_pct = 21; out_idle_pct = 65; end
                1: begin in_idle_pct = 65; out_idle_pct = 21; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            for (int n = 0; n < 170; n++)
            begin
                if (phase == 1 && n == 100)
                    drain();
                random_word();
            end
        end

        drain();
        repeat (400) @(posedge clk);
        $display("covered %0d words: %0d mix frames, %0d voice starts, %0d starts refused",
                 words_sent, sb.mixes, sb.starts, sb.full_starts);
        $display("six master volume settings under three handshake pressure patterns");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
